>>> rtl/pfs_pkg.sv
// Shared constants, types and state codes of the prefix-function stream block.
`default_nettype none

package pfs_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int IDX_W    = $clog2(MAX_LEN);
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int SYM_W    = 8;
  localparam int BORDER_W = 10;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    sym_t symbol;
    logic first;
    logic last;
  } pfs_item_t;

  typedef struct packed {
    logic [BORDER_W-1:0] border_length;
    logic                overflow;
    logic                end_of_string;
  } pfs_result_t;

  // Both stores share write enable and address; reads differ by one entry.
  typedef struct packed {
    logic wr_en;
    idx_t wr_addr;
    idx_t rd_sym_addr;
    idx_t rd_brd_addr;
  } pfs_mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CMP  = 2'b10
  } pfs_state_t;

endpackage

`default_nettype wire

>>> rtl/pfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/pfs_seq.sv
// Sequencer and shared compare unit that walks the fallback chain per byte.
`default_nettype none

module pfs_seq
  import pfs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire pfs_item_t    item,
  input  wire sym_t         sym_rd,
  input  wire idx_t         brd_rd,
  output logic              idle,
  output logic              done,
  output pfs_result_t       result,
  output pfs_mem_ctl_t      mem_ctl,
  output sym_t              wr_sym,
  output idx_t              wr_border
);

  pfs_state_t state_r, state_nxt;
  pos_t       pos_r, pos_nxt;
  idx_t       prev_r, prev_nxt;
  idx_t       j_r, j_nxt;
  sym_t       sym_r, sym_nxt;
  logic       last_r, last_nxt;

  pos_t eff_pos;
  idx_t j_start;
  idx_t j_fall;
  idx_t border;
  logic match;
  logic finish;
  logic last_now;

  assign eff_pos = item.first ? '0 : pos_r;
  // Clamp the starting index below the current position.
  assign j_start = (POS_W'(prev_r) >= eff_pos) ? IDX_W'(eff_pos - 1'b1) : prev_r;
  assign match   = (sym_rd == sym_r);
  assign finish  = match || (j_r == '0);
  assign j_fall  = (brd_rd < j_r) ? brd_rd : '0;
  assign idle    = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    j_nxt     = j_r;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    done      = 1'b0;
    border    = '0;
    last_now  = last_r;
    mem_ctl   = '0;
    wr_sym    = sym_r;
    result    = '0;
    unique case (state_r)
      ST_IDLE: begin
        wr_sym              = item.symbol;
        last_now            = item.last;
        mem_ctl.wr_addr     = IDX_W'(eff_pos);
        mem_ctl.rd_sym_addr = j_start;
        mem_ctl.rd_brd_addr = j_start - 1'b1;
        if (start) begin
          sym_nxt  = item.symbol;
          last_nxt = item.last;
          if (eff_pos >= POS_W'(MAX_LEN)) begin
            // Beyond the store: flag, do not store.
            done            = 1'b1;
            result.overflow = 1'b1;
          end else if (eff_pos == '0) begin
            done          = 1'b1;
            mem_ctl.wr_en = 1'b1;
            pos_nxt       = POS_W'(1);
            prev_nxt      = '0;
          end else begin
            pos_nxt   = eff_pos;
            j_nxt     = j_start;
            state_nxt = ST_CMP;
          end
          if (done && item.last) begin
            pos_nxt  = '0;
            prev_nxt = '0;
          end
        end
      end
      ST_CMP: begin
        mem_ctl.wr_addr     = IDX_W'(pos_r);
        mem_ctl.rd_sym_addr = j_fall;
        mem_ctl.rd_brd_addr = j_fall - 1'b1;
        if (finish) begin
          border        = j_r + IDX_W'(match);
          done          = 1'b1;
          mem_ctl.wr_en = 1'b1;
          prev_nxt      = border;
          pos_nxt       = pos_r + 1'b1;
          state_nxt     = ST_IDLE;
          if (last_r) begin
            pos_nxt  = '0;
            prev_nxt = '0;
          end
        end else begin
          j_nxt = j_fall;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    wr_border            = border;
    result.border_length = BORDER_W'(border);
    result.end_of_string = last_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      prev_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
    end
    j_r    <= j_nxt;
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_LEN))
    else $error("position beyond store depth");

  a_prev_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) |-> (POS_W'(prev_r) < pos_r))
    else $error("previous border not below position");

  a_prev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> (prev_r == '0))
    else $error("previous border set at string start");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (POS_W'(j_r) < pos_r))
    else $error("walk reads an entry not yet written");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> !start)
    else $error("item started during walk");

endmodule

`default_nettype wire

>>> rtl/prefix_function_stream.sv
// Top level of the streaming prefix-function (failure function) block.
`default_nettype none

// Streams a string in one byte per transaction and returns, for each byte,
// the length of the longest proper prefix that is also a suffix ending at
// that byte. in_tuser set starts a new string; in_tlast ends one, and the
// byte after it starts a new string whatever its in_tuser. Bytes and border
// values of the current string live in two RAMs of MAX_LEN entries; a byte
// at position MAX_LEN or later is not stored and returns border 0 with
// out_tuser set. The stores need no clearing pass: only entries of the
// current string are read. The first byte of a string and an overflow
// byte are answered from the idle state; any other byte then walks the
// fallback chain in the compare state. Each step is one compare of the
// new byte against the symbol RAM read port, with the border RAM read in
// the same cycle giving the next index. Fallback steps never exceed bytes
// seen. in_tready is low during the walk and while an untaken result
// blocks the output register.
module prefix_function_stream
  import pfs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tuser,   // [0] first
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [9:0] border_length, [15:10] zero
  output logic             out_tuser,  // [0] overflow
  output logic             out_tlast   // end_of_string
);

  pfs_item_t    item;
  pfs_result_t  result;
  pfs_result_t  out_r, out_nxt;
  pfs_mem_ctl_t mem_ctl;
  logic         out_valid_r, out_valid_nxt;
  logic         seq_idle;
  logic         seq_done;
  logic         start;
  sym_t         sym_rd;
  sym_t         wr_sym;
  idx_t         brd_rd;
  idx_t         wr_border;

  assign item.symbol = in_tdata[SYM_W-1:0];
  assign item.first  = in_tuser;
  assign item.last   = in_tlast;

  // Accept only when the walk is free and the result slot will be empty.
  assign in_tready = seq_idle && (!out_valid_r || out_tready);
  assign start     = in_tvalid && in_tready;

  pfs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .sym_rd    (sym_rd),
    .brd_rd    (brd_rd),
    .idle      (seq_idle),
    .done      (seq_done),
    .result    (result),
    .mem_ctl   (mem_ctl),
    .wr_sym    (wr_sym),
    .wr_border (wr_border)
  );

  // Bytes of the current string.
  pfs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_sym_ram (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (mem_ctl.wr_addr),
    .wr_data (wr_sym),
    .rd_addr (mem_ctl.rd_sym_addr),
    .rd_data (sym_rd)
  );

  // Border values of the current string.
  pfs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LEN)) u_brd_ram (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (mem_ctl.wr_addr),
    .wr_data (wr_border),
    .rd_addr (mem_ctl.rd_brd_addr),
    .rd_data (brd_rd)
  );

  // Output register: load a finished result, drop it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (seq_done) begin
      out_valid_nxt = 1'b1;
      out_nxt       = result;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_r.border_length);
  assign out_tuser  = out_r.overflow;
  assign out_tlast  = out_r.end_of_string;

endmodule

`default_nettype wire
